FILE: rtl/core/bws_pkg.sv
// ----------------------------------------------------------------------------
// Wheel speed mixer package
// Widths, constants, register codes and shared types for the wheel speed unit.
// ----------------------------------------------------------------------------
package bws_pkg;

    // Field widths.
    localparam int IR_W    = 7;
    localparam int COEF_W  = 8;
    localparam int LIMIT_W = 7;
    localparam int SPEED_W = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Internal arithmetic widths: one product, a sum of three products,
    // that sum after the shift, and a raw wheel speed.
    localparam int PROD_W = IR_W + COEF_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int SHR_W  = 11;
    localparam int RAW_W  = 12;

    // Stream word widths.
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 16;

    // Mixing and shaping constants.
    localparam int BASE_OFFSET = 95;
    localparam int SPEED_MAX   = 100;
    localparam int EVADE_SPEED = 70;
    localparam int SUM_SHIFT   = 5;

    // Pipeline depth: three mixing stages and the output register.
    localparam int PIPE_DEPTH = 4;

    // Register reset values.
    localparam logic signed [COEF_W-1:0] RST_OPP_NEAR   = -8'sd50;
    localparam logic signed [COEF_W-1:0] RST_OPP_FRONT  = -8'sd38;
    localparam logic signed [COEF_W-1:0] RST_OPP_SIDE   = -8'sd10;
    localparam logic signed [COEF_W-1:0] RST_SAME_NEAR  = -8'sd10;
    localparam logic signed [COEF_W-1:0] RST_SAME_FRONT = -8'sd7;
    localparam logic signed [COEF_W-1:0] RST_SAME_SIDE  = -8'sd8;
    localparam logic [LIMIT_W-1:0]       RST_MOTOR_LIMIT = 7'd30;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OPP_NEAR    = 3'd0,
        CFG_OPP_FRONT   = 3'd1,
        CFG_OPP_SIDE    = 3'd2,
        CFG_SAME_NEAR   = 3'd3,
        CFG_SAME_FRONT  = 3'd4,
        CFG_SAME_SIDE   = 3'd5,
        CFG_MOTOR_LIMIT = 3'd6
    } t_cfg_idx;

    // The six weights shared by both wheel mixers.
    typedef struct packed {
        logic signed [COEF_W-1:0] opp_near;
        logic signed [COEF_W-1:0] opp_front;
        logic signed [COEF_W-1:0] opp_side;
        logic signed [COEF_W-1:0] same_near;
        logic signed [COEF_W-1:0] same_front;
        logic signed [COEF_W-1:0] same_side;
    } t_coef_set;

endpackage

FILE: rtl/core/bws_wheel_mix.sv
// ----------------------------------------------------------------------------
// Wheel mixer
// Three-stage pipeline forming one raw wheel speed from six sensor readings:
// products, two shifted sums of three, then their total plus the offset.
// ----------------------------------------------------------------------------
module bws_wheel_mix (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  bws_pkg::t_coef_set                   i_coef,
    input  logic signed [bws_pkg::IR_W-1:0]      i_opp_near,
    input  logic signed [bws_pkg::IR_W-1:0]      i_opp_front,
    input  logic signed [bws_pkg::IR_W-1:0]      i_opp_side,
    input  logic signed [bws_pkg::IR_W-1:0]      i_same_near,
    input  logic signed [bws_pkg::IR_W-1:0]      i_same_front,
    input  logic signed [bws_pkg::IR_W-1:0]      i_same_side,
    output logic signed [bws_pkg::RAW_W-1:0]     o_raw
);
    import bws_pkg::*;

    logic signed [PROD_W-1:0] r_prod [6];
    logic signed [PROD_W-1:0] n_prod [6];
    logic signed [SUM_W-1:0]  w_opp_sum;
    logic signed [SUM_W-1:0]  w_same_sum;
    logic signed [SHR_W-1:0]  r_opp_shr;
    logic signed [SHR_W-1:0]  r_same_shr;
    logic signed [RAW_W-1:0]  r_raw;

    // Stage one: the six weighted readings.
    always_comb begin
        n_prod[0] = PROD_W'(i_coef.opp_near)   * PROD_W'(i_opp_near);
        n_prod[1] = PROD_W'(i_coef.opp_front)  * PROD_W'(i_opp_front);
        n_prod[2] = PROD_W'(i_coef.opp_side)   * PROD_W'(i_opp_side);
        n_prod[3] = PROD_W'(i_coef.same_near)  * PROD_W'(i_same_near);
        n_prod[4] = PROD_W'(i_coef.same_front) * PROD_W'(i_same_front);
        n_prod[5] = PROD_W'(i_coef.same_side)  * PROD_W'(i_same_side);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 6; k++) begin
                r_prod[k] <= n_prod[k];
            end
        end
    end

    // Stage two: each side's sum, floored by the arithmetic shift.
    assign w_opp_sum  = SUM_W'(r_prod[0]) + SUM_W'(r_prod[1]) + SUM_W'(r_prod[2]);
    assign w_same_sum = SUM_W'(r_prod[3]) + SUM_W'(r_prod[4]) + SUM_W'(r_prod[5]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_opp_shr  <= SHR_W'(w_opp_sum >>> SUM_SHIFT);
            r_same_shr <= SHR_W'(w_same_sum >>> SUM_SHIFT);
        end
    end

    // Stage three: both sides together with the base offset.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_raw <= RAW_W'(r_opp_shr) + RAW_W'(r_same_shr) + RAW_W'(BASE_OFFSET);
        end
    end

    assign o_raw = r_raw;

endmodule

FILE: rtl/core/braitenberg_wheel_speed_unit.sv
// ----------------------------------------------------------------------------
// Braitenberg wheel speed unit
// Obstacle avoidance mixer turning six infrared readings into wheel speeds.
// ----------------------------------------------------------------------------
// The unit takes one word of six sensor readings in every cycle unless the
// output stalls and returns one word of left and right wheel speeds, with
// the evasive flag on tuser, through a multiplier stage, a stage of shifted
// sums, the offset adder and the shaping stage that feeds the output
// register. All stages share one advance enable, so a stall on the output
// holds every word in place and the input is refused only while a finished
// word waits to be taken. Weights and the speed limit are written through the
// configuration port, which the user must do only while idle; nothing checks it.
module braitenberg_wheel_speed_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration write port.
    input  logic                                  i_cfg_we,
    input  logic [bws_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [bws_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    // Sensor words.
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // Fields from bit 0: ir_front_right, ir_center_right, ir_center_left,
    // ir_front_left, ir_left, ir_right (7 bits each), then zero fill.
    input  logic [bws_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
    // Speed words.
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // Fields from bit 0: speed_left (8 bits), speed_right (8 bits).
    output logic [bws_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    // Fields from bit 0: evasive (1 bit).
    output logic                                  m_axis_tuser
);
    import bws_pkg::*;

    t_coef_set               r_coef;
    logic [LIMIT_W-1:0]      r_motor_limit;
    logic [PIPE_DEPTH-1:0]   r_vld;
    logic                    w_en;

    logic signed [IR_W-1:0]  w_fr, w_cr, w_cl, w_fl, w_lt, w_rt;
    logic signed [RAW_W-1:0] w_raw_l, w_raw_r;
    logic signed [RAW_W-1:0] w_lim;
    logic signed [SPEED_W-1:0] n_spd_l, n_spd_r, r_spd_l, r_spd_r;
    logic                    n_evasive, r_evasive;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef.opp_near   <= RST_OPP_NEAR;
            r_coef.opp_front  <= RST_OPP_FRONT;
            r_coef.opp_side   <= RST_OPP_SIDE;
            r_coef.same_near  <= RST_SAME_NEAR;
            r_coef.same_front <= RST_SAME_FRONT;
            r_coef.same_side  <= RST_SAME_SIDE;
            r_motor_limit     <= RST_MOTOR_LIMIT;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_OPP_NEAR:    r_coef.opp_near   <= i_cfg_data;
                CFG_OPP_FRONT:   r_coef.opp_front  <= i_cfg_data;
                CFG_OPP_SIDE:    r_coef.opp_side   <= i_cfg_data;
                CFG_SAME_NEAR:   r_coef.same_near  <= i_cfg_data;
                CFG_SAME_FRONT:  r_coef.same_front <= i_cfg_data;
                CFG_SAME_SIDE:   r_coef.same_side  <= i_cfg_data;
                CFG_MOTOR_LIMIT: r_motor_limit     <= i_cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The whole pipeline moves whenever the output register is free or taken.
    assign w_en          = !r_vld[PIPE_DEPTH-1] || m_axis_tready;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], s_axis_tvalid};
        end
    end

    // Unpack the sensor word.
    assign w_fr = s_axis_tdata[1*IR_W-1:0*IR_W];
    assign w_cr = s_axis_tdata[2*IR_W-1:1*IR_W];
    assign w_cl = s_axis_tdata[3*IR_W-1:2*IR_W];
    assign w_fl = s_axis_tdata[4*IR_W-1:3*IR_W];
    assign w_lt = s_axis_tdata[5*IR_W-1:4*IR_W];
    assign w_rt = s_axis_tdata[6*IR_W-1:5*IR_W];

    // The left wheel takes the right-hand sensors as its opposite side.
    bws_wheel_mix u_mix_left (
        .i_clk        (i_clk),
        .i_en         (w_en),
        .i_coef       (r_coef),
        .i_opp_near   (w_cr),
        .i_opp_front  (w_fr),
        .i_opp_side   (w_rt),
        .i_same_near  (w_cl),
        .i_same_front (w_fl),
        .i_same_side  (w_lt),
        .o_raw        (w_raw_l)
    );

    bws_wheel_mix u_mix_right (
        .i_clk        (i_clk),
        .i_en         (w_en),
        .i_coef       (r_coef),
        .i_opp_near   (w_cl),
        .i_opp_front  (w_fl),
        .i_opp_side   (w_lt),
        .i_same_near  (w_cr),
        .i_same_front (w_fr),
        .i_same_side  (w_rt),
        .o_raw        (w_raw_r)
    );

    // A limit above full speed acts as full speed.
    assign w_lim = (r_motor_limit > LIMIT_W'(SPEED_MAX)) ? RAW_W'(SPEED_MAX)
                                                         : RAW_W'(r_motor_limit);

    // Saturate, lift small speeds out of the dead band.
    function automatic logic signed [SPEED_W-1:0] shape_speed(
        input logic signed [RAW_W-1:0] raw,
        input logic signed [RAW_W-1:0] lim
    );
        logic signed [RAW_W-1:0] res;
        if (raw > RAW_W'(SPEED_MAX)) begin
            res = RAW_W'(SPEED_MAX);
        end else if (raw < -RAW_W'(SPEED_MAX)) begin
            res = -RAW_W'(SPEED_MAX);
        end else if (raw > 0 && raw < lim) begin
            res = lim;
        end else if (raw < 0 && raw > -lim) begin
            res = -lim;
        end else begin
            res = raw;
        end
        return res[SPEED_W-1:0];
    endfunction

    // Shaping stage, with the evasive turn when both wheels sit inside the band.
    always_comb begin
        n_evasive = (w_raw_l < w_lim) && (w_raw_l > -w_lim) &&
                    (w_raw_r < w_lim) && (w_raw_r > -w_lim);
        if (n_evasive) begin
            n_spd_l = -SPEED_W'(EVADE_SPEED);
            n_spd_r = SPEED_W'(EVADE_SPEED);
        end else begin
            n_spd_l = shape_speed(w_raw_l, w_lim);
            n_spd_r = shape_speed(w_raw_r, w_lim);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_spd_l   <= n_spd_l;
            r_spd_r   <= n_spd_r;
            r_evasive <= n_evasive;
        end
    end

    assign m_axis_tvalid = r_vld[PIPE_DEPTH-1];
    assign m_axis_tdata  = {r_spd_r, r_spd_l};
    assign m_axis_tuser  = r_evasive;

endmodule

FILE: rtl/core/bws_checker.sv
// ----------------------------------------------------------------------------
// Wheel speed unit checker
// Port-level assertions on the wheel speed unit, bound to the top level.
// ----------------------------------------------------------------------------
module bws_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tready,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [bws_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                               m_axis_tuser
);
    import bws_pkg::*;

    logic signed [SPEED_W-1:0] w_spd_l;
    logic signed [SPEED_W-1:0] w_spd_r;

    assign w_spd_l = m_axis_tdata[SPEED_W-1:0];
    assign w_spd_r = m_axis_tdata[2*SPEED_W-1:SPEED_W];

    // An evasive word always commands the fixed turn.
    a_evasive_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            (w_spd_l == -SPEED_W'(EVADE_SPEED) && w_spd_r == SPEED_W'(EVADE_SPEED)))
        else $error("evasive word without the fixed turn speeds");

    // Every output speed stays within full scale.
    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (w_spd_l <= SPEED_W'(SPEED_MAX) && w_spd_l >= -SPEED_W'(SPEED_MAX) &&
             w_spd_r <= SPEED_W'(SPEED_MAX) && w_spd_r >= -SPEED_W'(SPEED_MAX)))
        else $error("wheel speed beyond full scale");

    // A stalled output word holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled output word changed");

    // The input is refused only while an output word waits to be taken.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input refused without output back-pressure");

endmodule

bind braitenberg_wheel_speed_unit bws_checker u_bws_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
